>>> sv/helc_pkg.sv
package helc_pkg;

   localparam int unsigned WinWidth   = 20;
   localparam int unsigned WordWidth  = 32;
   localparam int unsigned ClassWidth = 2;
   localparam int unsigned SlotWidth  = 3;
   localparam int unsigned KindWidth  = 2;
   localparam int unsigned NumSummary = 7;
   localparam int unsigned NumIntegral = 3;

   localparam int unsigned ReqDataWidth = 72;
   localparam int unsigned RspDataWidth = 40;
   localparam int unsigned CsrIndexWidth = 2;

   localparam logic [KindWidth-1:0] KIND_SUMMARY  = 2'd0;
   localparam logic [KindWidth-1:0] KIND_INTEGRAL = 2'd1;
   localparam logic [KindWidth-1:0] KIND_END      = 2'd2;

   localparam logic [SlotWidth-1:0] SLOT_ERRCODE  = 3'd0;
   localparam logic [SlotWidth-1:0] SLOT_EVENTS   = 3'd1;
   localparam logic [SlotWidth-1:0] SLOT_PATTERNS = 3'd2;
   localparam logic [SlotWidth-1:0] SLOT_PHASE    = 3'd3;
   localparam logic [SlotWidth-1:0] SLOT_SEED     = 3'd4;
   localparam logic [SlotWidth-1:0] SLOT_POLARITY = 3'd5;
   localparam logic [SlotWidth-1:0] SLOT_QRTHEL   = 3'd6;

   localparam logic [ClassWidth-1:0] CLASS_LOW     = 2'd0;
   localparam logic [ClassWidth-1:0] CLASS_HIGH    = 2'd1;
   localparam logic [ClassWidth-1:0] CLASS_INVALID = 2'd2;

   localparam logic [CsrIndexWidth-1:0] CSR_LOW_MIN  = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_LOW_MAX  = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_HIGH_MIN = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_HIGH_MAX = 2'd3;

   localparam logic [WinWidth-1:0] RESET_LOW_MIN  = 20'd30000;
   localparam logic [WinWidth-1:0] RESET_LOW_MAX  = 20'd60000;
   localparam logic [WinWidth-1:0] RESET_HIGH_MIN = 20'd75000;
   localparam logic [WinWidth-1:0] RESET_HIGH_MAX = 20'd95000;

   localparam logic [WordWidth-1:0] ERR_ERRCODE   = 32'h0101_0000;
   localparam logic [WordWidth-1:0] ERR_EVENTS    = 32'h0102_0000;
   localparam logic [WordWidth-1:0] ERR_PATTERNS  = 32'h0104_0000;
   localparam logic [WordWidth-1:0] ERR_PHASE     = 32'h0108_0000;
   localparam logic [WordWidth-1:0] ERR_SEED      = 32'h0110_0000;
   localparam logic [WordWidth-1:0] ERR_SEED_BIT  = 32'h0120_0000;
   localparam logic [WordWidth-1:0] ERR_POLARITY  = 32'h0140_0000;
   localparam logic [WordWidth-1:0] ERR_QRTHEL    = 32'h0180_0000;
   localparam logic [WordWidth-1:0] ERR_CRATE_CLS = 32'h1000_0000;
   localparam logic [WordWidth-1:0] ERR_PRED_HEL  = 32'h2000_0000;
   localparam logic [WordWidth-1:0] ERR_PRED_SYNC = 32'h4000_0000;
   localparam logic [WordWidth-1:0] ERR_SETTLE    = 32'h8000_0000;

   localparam logic [WordWidth-1:0] ERR_NO_PREDICT = 32'd16;
   localparam logic [WordWidth-1:0] HEL_INVALID    = 32'h0000_1000;

   typedef struct packed {
      logic [WinWidth-1:0] low_min;
      logic [WinWidth-1:0] low_max;
      logic [WinWidth-1:0] high_min;
      logic [WinWidth-1:0] high_max;
   } window_type;

endpackage

>>> sv/helicity_consistency_checker_core.sv
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tuser kind, tdata slot..secondary_found
// rsp      out        rsp_tvalid/rsp_tready  tdata error_word and three classes
// csr      in         csr_valid/csr_ready    csr_index, csr_data (window edges)
//
// A request is taken into an input register and handled from there, so one
// request is accepted every cycle unless an end-of-event request waits. An
// end-of-event request loads the response register at the edge where it leaves
// the input register. Reset clears the control and accumulated state (not the
// data registers) and loads the default windows. Only an end-of-event request
// waits for a full response register; csr_ready is always high.
module helicity_consistency_checker_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // tuser: kind[1:0]
   input  logic [helc_pkg::KindWidth-1:0]          req_tuser,
   // tdata: slot[2:0], primary_value[34:3], secondary_value[66:35],
   // primary_found[67], secondary_found[68], zero fill[71:69]
   input  logic [helc_pkg::ReqDataWidth-1:0]       req_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // tdata: error_word[31:0], helicity_class[33:32], sync_class[35:34],
   // settle_class[37:36], zero fill[39:38]
   output logic [helc_pkg::RspDataWidth-1:0]       rsp_tdata,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [helc_pkg::CsrIndexWidth-1:0]      csr_index,
   input  logic [helc_pkg::WinWidth-1:0]           csr_data
);

   localparam int unsigned W  = helc_pkg::WordWidth;
   localparam int unsigned CW = helc_pkg::ClassWidth;
   localparam int unsigned NS = helc_pkg::NumSummary;
   localparam int unsigned NI = helc_pkg::NumIntegral;

   helc_pkg::window_type window_ff, window_in;

   logic                              in_valid_ff;
   logic [helc_pkg::KindWidth-1:0]    in_kind_ff;
   logic [helc_pkg::SlotWidth-1:0]    in_slot_ff;
   logic [W-1:0]                      in_prim_ff;
   logic [W-1:0]                      in_sec_ff;
   logic                              in_pf_ff;
   logic                              in_sf_ff;

   logic [W-1:0]  error_accum_ff, error_accum_in;
   logic [W-1:0]  summary_ff [NS];
   logic [W-1:0]  summary_in [NS];
   logic [W-1:0]  event_offset_ff, event_offset_in;
   logic [W-1:0]  pattern_offset_ff, pattern_offset_in;
   logic [CW-1:0] class_ff [2*NI];
   logic [CW-1:0] class_in [2*NI];

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [helc_pkg::RspDataWidth-1:0]    rsp_data_ff, rsp_data_in;

   logic          out_free;
   logic          advance;
   logic          req_fire;
   logic [CW-1:0] prim_class;
   logic [CW-1:0] sec_class;

   logic [W-1:0]  prim_word;
   logic [W-1:0]  err_base;
   logic [W-1:0]  err_e1;
   logic [W-1:0]  err_e2;
   logic [W-1:0]  err_e3;
   logic [W-1:0]  hel_value;
   logic [W-1:0]  pred_value;
   logic          sync_high;
   logic          phase_zero;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (in_kind_ff != helc_pkg::KIND_END || out_free);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   helc_classify u_class_prim (
      .windows     (window_ff),
      .value       (in_prim_ff),
      .value_class (prim_class)
   );

   helc_classify u_class_sec (
      .windows     (window_ff),
      .value       (in_sec_ff),
      .value_class (sec_class)
   );

   always_comb begin
      window_in = window_ff;
      if (csr_valid) begin
         case (csr_index)
            helc_pkg::CSR_LOW_MIN:  window_in.low_min  = csr_data;
            helc_pkg::CSR_LOW_MAX:  window_in.low_max  = csr_data;
            helc_pkg::CSR_HIGH_MIN: window_in.high_min = csr_data;
            helc_pkg::CSR_HIGH_MAX: window_in.high_max = csr_data;
            default: window_in = window_ff;
         endcase
      end
   end

   always_comb begin
      error_accum_in    = error_accum_ff;
      event_offset_in   = event_offset_ff;
      pattern_offset_in = pattern_offset_ff;
      for (int i = 0; i < NS; i++) begin
         summary_in[i] = summary_ff[i];
      end
      for (int i = 0; i < 2*NI; i++) begin
         class_in[i] = class_ff[i];
      end
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      prim_word = '0;
      for (int i = 0; i < NS; i++) begin
         if (in_slot_ff == 3'(i)) begin
            prim_word = summary_ff[i];
         end
      end
      if (in_pf_ff) begin
         prim_word = in_prim_ff;
      end
      err_base = (in_pf_ff && in_slot_ff == helc_pkg::SLOT_ERRCODE) ? in_prim_ff
                                                                    : error_accum_ff;

      hel_value  = (class_ff[0] == helc_pkg::CLASS_LOW)  ? '0 :
                   (class_ff[0] == helc_pkg::CLASS_HIGH) ? W'(1) : helc_pkg::HEL_INVALID;
      pred_value = {{(W-1){1'b0}}, summary_ff[helc_pkg::SLOT_SEED][0]}
                   ^ summary_ff[helc_pkg::SLOT_POLARITY];
      sync_high  = class_ff[1] == helc_pkg::CLASS_HIGH;
      phase_zero = summary_ff[helc_pkg::SLOT_PHASE] == '0;

      err_e1 = error_accum_ff;
      if (class_ff[0] != class_ff[3] || class_ff[1] != class_ff[4]
          || class_ff[2] != class_ff[5]) begin
         err_e1 = err_e1 | helc_pkg::ERR_CRATE_CLS;
      end
      err_e2 = err_e1;
      if (err_e1 != helc_pkg::ERR_NO_PREDICT && class_ff[2] == helc_pkg::CLASS_LOW
          && hel_value != pred_value) begin
         err_e2 = err_e2 | helc_pkg::ERR_PRED_HEL;
      end
      err_e3 = err_e2;
      if (err_e2 != helc_pkg::ERR_NO_PREDICT && class_ff[2] == helc_pkg::CLASS_LOW
          && sync_high != phase_zero) begin
         err_e3 = err_e3 | helc_pkg::ERR_PRED_SYNC;
      end
      if (class_ff[2] != helc_pkg::CLASS_LOW) begin
         err_e3 = err_e3 | helc_pkg::ERR_SETTLE;
      end

      if (advance) begin
         case (in_kind_ff)
            helc_pkg::KIND_SUMMARY: begin
               if (in_slot_ff != 3'(NS)) begin
                  for (int i = 0; i < NS; i++) begin
                     if (in_slot_ff == 3'(i)) begin
                        summary_in[i] = prim_word;
                     end
                  end
                  error_accum_in = err_base;
                  if (in_sf_ff) begin
                     case (in_slot_ff)
                        helc_pkg::SLOT_ERRCODE: begin
                           if (err_base != in_sec_ff) begin
                              error_accum_in = err_base | helc_pkg::ERR_ERRCODE;
                           end
                        end
                        helc_pkg::SLOT_EVENTS: begin
                           if (prim_word != in_sec_ff - event_offset_ff) begin
                              event_offset_in = in_sec_ff - prim_word;
                              error_accum_in  = err_base | helc_pkg::ERR_EVENTS;
                           end
                        end
                        helc_pkg::SLOT_PATTERNS: begin
                           if (prim_word != in_sec_ff - pattern_offset_ff) begin
                              pattern_offset_in = in_sec_ff - prim_word;
                              error_accum_in    = err_base | helc_pkg::ERR_PATTERNS;
                           end
                        end
                        helc_pkg::SLOT_PHASE: begin
                           if (prim_word != in_sec_ff) begin
                              error_accum_in = err_base | helc_pkg::ERR_PHASE;
                           end
                        end
                        helc_pkg::SLOT_SEED: begin
                           if (prim_word != in_sec_ff) begin
                              error_accum_in = err_base | helc_pkg::ERR_SEED;
                           end
                           if (prim_word[0] != in_sec_ff[0]) begin
                              error_accum_in = error_accum_in | helc_pkg::ERR_SEED_BIT;
                           end
                        end
                        helc_pkg::SLOT_POLARITY: begin
                           if (prim_word != in_sec_ff) begin
                              error_accum_in = err_base | helc_pkg::ERR_POLARITY;
                           end
                        end
                        helc_pkg::SLOT_QRTHEL: begin
                           if (prim_word != in_sec_ff) begin
                              error_accum_in = err_base | helc_pkg::ERR_QRTHEL;
                           end
                        end
                        default: error_accum_in = err_base;
                     endcase
                  end
               end
            end
            helc_pkg::KIND_INTEGRAL: begin
               for (int i = 0; i < NI; i++) begin
                  if (in_slot_ff == 3'(i)) begin
                     class_in[i]      = prim_class;
                     class_in[i + NI] = sec_class;
                  end
               end
            end
            helc_pkg::KIND_END: begin
               error_accum_in = err_e3;
               rsp_valid_in   = 1'b1;
               rsp_data_in    = {2'b00, class_ff[2], class_ff[1], class_ff[0], err_e3};
            end
            default: error_accum_in = error_accum_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff.low_min  <= helc_pkg::RESET_LOW_MIN;
         window_ff.low_max  <= helc_pkg::RESET_LOW_MAX;
         window_ff.high_min <= helc_pkg::RESET_HIGH_MIN;
         window_ff.high_max <= helc_pkg::RESET_HIGH_MAX;
         in_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         error_accum_ff     <= '0;
         event_offset_ff    <= '0;
         pattern_offset_ff  <= '0;
         for (int i = 0; i < NS; i++) begin
            summary_ff[i] <= '0;
         end
         for (int i = 0; i < 2*NI; i++) begin
            class_ff[i] <= helc_pkg::CLASS_LOW;
         end
      end else begin
         window_ff         <= window_in;
         error_accum_ff    <= error_accum_in;
         event_offset_ff   <= event_offset_in;
         pattern_offset_ff <= pattern_offset_in;
         for (int i = 0; i < NS; i++) begin
            summary_ff[i] <= summary_in[i];
         end
         for (int i = 0; i < 2*NI; i++) begin
            class_ff[i] <= class_in[i];
         end
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (req_fire) begin
         in_kind_ff <= req_tuser;
         in_slot_ff <= req_tdata[2:0];
         in_prim_ff <= req_tdata[34:3];
         in_sec_ff  <= req_tdata[66:35];
         in_pf_ff   <= req_tdata[67];
         in_sf_ff   <= req_tdata[68];
      end
   end

endmodule

>>> sv/helc_classify.sv
module helc_classify (
   input  helc_pkg::window_type                   windows,
   input  logic [helc_pkg::WordWidth-1:0]         value,
   output logic [helc_pkg::ClassWidth-1:0]        value_class
);

   logic [helc_pkg::WordWidth-1:0] low_min;
   logic [helc_pkg::WordWidth-1:0] low_max;
   logic [helc_pkg::WordWidth-1:0] high_min;
   logic [helc_pkg::WordWidth-1:0] high_max;

   assign low_min  = {{(helc_pkg::WordWidth-helc_pkg::WinWidth){1'b0}}, windows.low_min};
   assign low_max  = {{(helc_pkg::WordWidth-helc_pkg::WinWidth){1'b0}}, windows.low_max};
   assign high_min = {{(helc_pkg::WordWidth-helc_pkg::WinWidth){1'b0}}, windows.high_min};
   assign high_max = {{(helc_pkg::WordWidth-helc_pkg::WinWidth){1'b0}}, windows.high_max};

   always_comb begin
      if (value >= low_min && value <= low_max) begin
         value_class = helc_pkg::CLASS_LOW;
      end else if (value >= high_min && value <= high_max) begin
         value_class = helc_pkg::CLASS_HIGH;
      end else begin
         value_class = helc_pkg::CLASS_INVALID;
      end
   end

endmodule

>>> verif/helicity_consistency_checker_core_test.sv
module helicity_consistency_checker_core_test;
   import helc_pkg::*;

   localparam logic [KindWidth-1:0] KIND_UNUSED = 2'd3;
   localparam logic [SlotWidth-1:0] SLOT_UNUSED = 3'd7;
   localparam logic [SlotWidth-1:0] INT_HELICITY = 3'd0;
   localparam logic [SlotWidth-1:0] INT_SYNC = 3'd1;
   localparam logic [SlotWidth-1:0] INT_SETTLE = 3'd2;
   localparam logic [SlotWidth-1:0] INT_SPARE = 3'd3;
   localparam int HoldCycles = 300;

   typedef struct packed {
      logic [KindWidth-1:0] kind;
      logic [SlotWidth-1:0] slot;
      logic [WordWidth-1:0] prim;
      logic [WordWidth-1:0] sec;
      logic                 pf;
      logic                 sf;
   } request_type;

   typedef struct packed {
      logic [WordWidth-1:0]  error_word;
      logic [ClassWidth-1:0] hel_cls;
      logic [ClassWidth-1:0] sync_cls;
      logic [ClassWidth-1:0] settle_cls;
   } report_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [KindWidth-1:0]     req_tuser;
   logic [ReqDataWidth-1:0]  req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RspDataWidth-1:0]  rsp_tdata;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [WinWidth-1:0]      csr_data;

   window_type           win;
   logic [WordWidth-1:0] err_accum;
   logic [WordWidth-1:0] evt_offset;
   logic [WordWidth-1:0] pat_offset;
   logic [WordWidth-1:0] prim_word [0:NumSummary-1];
   logic [ClassWidth-1:0] cls [0:2*NumIntegral-1];
   report_type           pending_reports [$];

   int                   errors = 0;
   int unsigned          burst_left = 0;
   bit                   gaps_on = 1'b1;
   bit                   hold_on = 1'b0;
   logic [WordWidth-1:0] event_number = '0;

   helicity_consistency_checker_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [ClassWidth-1:0] classify_integral(input logic [WordWidth-1:0] v);
      if (v >= {12'd0, win.low_min} && v <= {12'd0, win.low_max}) return CLASS_LOW;
      if (v >= {12'd0, win.high_min} && v <= {12'd0, win.high_max}) return CLASS_HIGH;
      return CLASS_INVALID;
   endfunction

   function automatic bit track_helicity_item(input request_type rq, output report_type rep);
      logic [WordWidth-1:0] p;
      logic [WordWidth-1:0] hel_value;
      logic [WordWidth-1:0] predicted;
      bit                   produced;
      produced = 1'b0;
      rep = '0;
      case (rq.kind)
         KIND_SUMMARY: begin
            if (rq.slot != SLOT_UNUSED) begin
               if (rq.pf) begin
                  prim_word[rq.slot] = rq.prim;
                  if (rq.slot == SLOT_ERRCODE) err_accum = rq.prim;
               end
               if (rq.sf) begin
                  p = prim_word[rq.slot];
                  case (rq.slot)
                     SLOT_ERRCODE: if (err_accum != rq.sec) err_accum |= ERR_ERRCODE;
                     SLOT_EVENTS: begin
                        if (p != rq.sec - evt_offset) begin
                           evt_offset = rq.sec - p;
                           err_accum |= ERR_EVENTS;
                        end
                     end
                     SLOT_PATTERNS: begin
                        if (p != rq.sec - pat_offset) begin
                           pat_offset = rq.sec - p;
                           err_accum |= ERR_PATTERNS;
                        end
                     end
                     SLOT_PHASE: if (p != rq.sec) err_accum |= ERR_PHASE;
                     SLOT_SEED: begin
                        if (p != rq.sec) err_accum |= ERR_SEED;
                        if (p[0] != rq.sec[0]) err_accum |= ERR_SEED_BIT;
                     end
                     SLOT_POLARITY: if (p != rq.sec) err_accum |= ERR_POLARITY;
                     SLOT_QRTHEL: if (p != rq.sec) err_accum |= ERR_QRTHEL;
                     default: ;
                  endcase
               end
            end
         end
         KIND_INTEGRAL: begin
            if (rq.slot <= INT_SETTLE) begin
               cls[rq.slot] = classify_integral(rq.prim);
               cls[rq.slot + NumIntegral] = classify_integral(rq.sec);
            end
         end
         KIND_END: begin
            hel_value = (cls[INT_HELICITY] == CLASS_LOW) ? 32'd0 :
                        (cls[INT_HELICITY] == CLASS_HIGH) ? 32'd1 : HEL_INVALID;
            predicted = {31'd0, prim_word[SLOT_SEED][0]} ^ prim_word[SLOT_POLARITY];
            if (cls[INT_HELICITY] != cls[INT_HELICITY + NumIntegral] ||
                cls[INT_SYNC] != cls[INT_SYNC + NumIntegral] ||
                cls[INT_SETTLE] != cls[INT_SETTLE + NumIntegral])
               err_accum |= ERR_CRATE_CLS;
            if (err_accum != ERR_NO_PREDICT && cls[INT_SETTLE] == CLASS_LOW &&
                hel_value != predicted)
               err_accum |= ERR_PRED_HEL;
            if (err_accum != ERR_NO_PREDICT && cls[INT_SETTLE] == CLASS_LOW &&
                (cls[INT_SYNC] == CLASS_HIGH) != (prim_word[SLOT_PHASE] == 0))
               err_accum |= ERR_PRED_SYNC;
            if (cls[INT_SETTLE] != CLASS_LOW) err_accum |= ERR_SETTLE;
            rep.error_word = err_accum;
            rep.hel_cls = cls[INT_HELICITY];
            rep.sync_cls = cls[INT_SYNC];
            rep.settle_cls = cls[INT_SETTLE];
            produced = 1'b1;
         end
         default: ;
      endcase
      return produced;
   endfunction

   task automatic compare_field(input string name, input logic [WordWidth-1:0] want,
                                input logic [WordWidth-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      request_type rq;
      report_type  want;
      report_type  got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.error_word = rsp_tdata[31:0];
            got.hel_cls = rsp_tdata[33:32];
            got.sync_cls = rsp_tdata[35:34];
            got.settle_cls = rsp_tdata[37:36];
            if (pending_reports.size() == 0) begin
               $display("%0t: response expected none, got %h", $time, rsp_tdata);
               errors++;
            end else begin
               want = pending_reports.pop_front();
               compare_field("error_word", want.error_word, got.error_word);
               compare_field("helicity_class", 32'(want.hel_cls), 32'(got.hel_cls));
               compare_field("sync_class", 32'(want.sync_cls), 32'(got.sync_cls));
               compare_field("settle_class", 32'(want.settle_cls), 32'(got.settle_cls));
            end
         end
         if (req_tvalid && req_tready) begin
            rq.kind = req_tuser;
            rq.slot = req_tdata[2:0];
            rq.prim = req_tdata[34:3];
            rq.sec = req_tdata[66:35];
            rq.pf = req_tdata[67];
            rq.sf = req_tdata[68];
            if (track_helicity_item(rq, want)) pending_reports.push_back(want);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LOW_MIN: win.low_min = csr_data;
               CSR_LOW_MAX: win.low_max = csr_data;
               CSR_HIGH_MIN: win.high_min = csr_data;
               CSR_HIGH_MAX: win.high_max = csr_data;
               default: ;
            endcase
         end
      end
   end

   // The receiver runs through phases of no stalls and of light, heavy and alternating stalls.
   initial begin
      int unsigned stall_tick;
      stall_tick = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_on) begin
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_on = 1'b0;
         end else begin
            stall_tick++;
            case (stall_tick[7:6])
               2'd0: rsp_tready <= 1'b1;
               2'd1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2'd2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= stall_tick[2];
            endcase
         end
      end
   end

   function automatic request_type make_request(input logic [KindWidth-1:0] kind,
                                                input logic [SlotWidth-1:0] slot,
                                                input logic [WordWidth-1:0] prim,
                                                input logic [WordWidth-1:0] sec,
                                                input int unsigned pf, input int unsigned sf);
      request_type rq;
      rq.kind = kind;
      rq.slot = slot;
      rq.prim = prim;
      rq.sec = sec;
      rq.pf = (pf != 0);
      rq.sf = (sf != 0);
      return rq;
   endfunction

   task automatic send_request(input request_type rq);
      if (gaps_on && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      if (burst_left > 0) burst_left--;
      req_tuser <= rq.kind;
      req_tdata <= {3'b000, rq.sf, rq.pf, rq.sec, rq.prim, rq.slot};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_window(input logic [CsrIndexWidth-1:0] index,
                               input logic [WinWidth-1:0] value);
      csr_index <= index;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_windows(input logic [WinWidth-1:0] lo_min, input logic [WinWidth-1:0] lo_max,
                              input logic [WinWidth-1:0] hi_min, input logic [WinWidth-1:0] hi_max);
      wait_until_drained();
      write_window(CSR_LOW_MIN, lo_min);
      write_window(CSR_LOW_MAX, lo_max);
      write_window(CSR_HIGH_MIN, hi_min);
      write_window(CSR_HIGH_MAX, hi_max);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [WordWidth-1:0] in_window(input bit high_side);
      if (high_side) return $urandom_range(win.high_max, win.high_min);
      return $urandom_range(win.low_max, win.low_min);
   endfunction

   // Integrals land on, just outside and inside the window edges, or anywhere at all.
   function automatic logic [WordWidth-1:0] pick_integral();
      case ($urandom_range(0, 13))
         0: return {12'd0, win.low_min};
         1: return {12'd0, win.low_max};
         2: return {12'd0, win.low_min} - 1;
         3: return {12'd0, win.low_max} + 1;
         4: return {12'd0, win.high_min};
         5: return {12'd0, win.high_max};
         6: return {12'd0, win.high_min} - 1;
         7: return {12'd0, win.high_max} + 1;
         8, 9: return $urandom;
         10, 11: return in_window(1'b0);
         default: return in_window(1'b1);
      endcase
   endfunction

   function automatic logic [WordWidth-1:0] mostly_same(input logic [WordWidth-1:0] v);
      case ($urandom_range(0, 19))
         0: return $urandom;
         1: return v ^ (32'd1 << $urandom_range(0, 31));
         default: return v;
      endcase
   endfunction

   task automatic send_integral(input logic [SlotWidth-1:0] slot, input logic [WordWidth-1:0] v);
      send_request(make_request(KIND_INTEGRAL, slot, v,
                                ($urandom_range(0, 7) != 0) ? v : pick_integral(),
                                $urandom_range(0, 1), $urandom_range(0, 1)));
   endtask

   task automatic send_end_marker();
      send_request(make_request(KIND_END, 3'($urandom_range(0, 7)), $urandom, $urandom,
                                $urandom_range(0, 1), $urandom_range(0, 1)));
   endtask

   task automatic send_clean_event();
      logic [WordWidth-1:0] p [0:NumSummary-1];
      logic [WordWidth-1:0] s;
      bit                   hel_high;
      event_number += 1;
      p[SLOT_ERRCODE] = ($urandom_range(0, 3) == 0) ? ERR_NO_PREDICT :
                        ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
      p[SLOT_EVENTS] = event_number;
      p[SLOT_PATTERNS] = event_number >> 2;
      p[SLOT_PHASE] = $urandom_range(0, 3);
      p[SLOT_SEED] = $urandom;
      p[SLOT_POLARITY] = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 1);
      p[SLOT_QRTHEL] = $urandom_range(0, 1);
      for (int i = 0; i < NumSummary; i++) begin
         case (i)
            SLOT_EVENTS: s = p[i] + evt_offset;
            SLOT_PATTERNS: s = p[i] + pat_offset;
            default: s = p[i];
         endcase
         send_request(make_request(KIND_SUMMARY, 3'(i), p[i], mostly_same(s),
                                   $urandom_range(0, 15), $urandom_range(0, 15)));
      end
      hel_high = p[SLOT_SEED][0] ^ p[SLOT_POLARITY][0];
      send_integral(INT_HELICITY,
                    ($urandom_range(0, 3) != 0) ? in_window(hel_high) : pick_integral());
      send_integral(INT_SYNC,
                    ($urandom_range(0, 3) != 0) ? in_window(p[SLOT_PHASE] == 0) : pick_integral());
      send_integral(INT_SETTLE,
                    ($urandom_range(0, 4) != 0) ? in_window(1'b0) : pick_integral());
      send_end_marker();
   endtask

   task automatic send_noise_event();
      repeat ($urandom_range(1, 14)) begin
         send_request(make_request(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                                   ($urandom_range(0, 1) != 0) ? pick_integral() : $urandom,
                                   ($urandom_range(0, 1) != 0) ? pick_integral() : $urandom,
                                   $urandom_range(0, 1), $urandom_range(0, 1)));
      end
      if ($urandom_range(0, 3) != 0) send_end_marker();
   endtask

   task automatic test_directed_cases();
      send_request(make_request(KIND_SUMMARY, SLOT_ERRCODE, ERR_NO_PREDICT, ERR_NO_PREDICT, 1, 1));
      send_request(make_request(KIND_SUMMARY, SLOT_EVENTS, 32'h0, 32'hFFFF_FFFF, 1, 1));
      send_request(make_request(KIND_SUMMARY, SLOT_PATTERNS, 32'hFFFF_FFFF, 32'h0, 1, 1));
      send_request(make_request(KIND_SUMMARY, SLOT_PHASE, 32'h0, 32'h0, 1, 1));
      send_request(make_request(KIND_SUMMARY, SLOT_SEED, 32'h1, 32'h0, 1, 1));
      send_request(make_request(KIND_SUMMARY, SLOT_POLARITY, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1, 1));
      send_request(make_request(KIND_SUMMARY, SLOT_QRTHEL, 32'h5, 32'h6, 1, 0));
      send_request(make_request(KIND_SUMMARY, SLOT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1));
      send_request(make_request(KIND_INTEGRAL, INT_HELICITY, 32'd30000, 32'd60000, 1, 1));
      send_request(make_request(KIND_INTEGRAL, INT_SYNC, 32'd75000, 32'd95000, 0, 0));
      send_request(make_request(KIND_INTEGRAL, INT_SETTLE, 32'd29999, 32'd95001, 1, 1));
      send_request(make_request(KIND_INTEGRAL, INT_SPARE, 32'h0, 32'h0, 1, 1));
      send_request(make_request(KIND_INTEGRAL, SLOT_UNUSED, 32'hFFFF_FFFF, 32'h0, 1, 1));
      send_request(make_request(KIND_UNUSED, SLOT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1));
      send_request(make_request(KIND_END, SLOT_ERRCODE, 32'h0, 32'h0, 0, 0));
      // A missing primary errcode compares against the error word accumulated in the last event.
      send_request(make_request(KIND_SUMMARY, SLOT_ERRCODE, 32'h0, 32'h0, 0, 1));
      send_request(make_request(KIND_SUMMARY, SLOT_EVENTS, 32'h1, 32'h0, 1, 1));
      send_request(make_request(KIND_INTEGRAL, INT_SETTLE, 32'd60000, 32'd60001, 1, 1));
      send_request(make_request(KIND_INTEGRAL, INT_HELICITY, 32'd60001, 32'd60001, 1, 1));
      send_request(make_request(KIND_END, SLOT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1));
      // An errcode that arrives late overwrites the bits set before it.
      send_request(make_request(KIND_SUMMARY, SLOT_PATTERNS, 32'h7, 32'h9, 1, 1));
      send_request(make_request(KIND_SUMMARY, SLOT_ERRCODE, 32'h0, 32'h0, 1, 1));
      send_request(make_request(KIND_INTEGRAL, INT_SETTLE, 32'hFFFF_FFFF, 32'h0, 1, 1));
      send_request(make_request(KIND_INTEGRAL, INT_SETTLE, 32'd45000, 32'd45000, 1, 1));
      send_request(make_request(KIND_END, SLOT_ERRCODE, 32'h0, 32'h0, 0, 0));
   endtask

   task automatic test_window_settings();
      logic [WinWidth-1:0] a;
      logic [WinWidth-1:0] b;
      logic [WinWidth-1:0] c;
      logic [WinWidth-1:0] d;
      for (int setting = 0; setting < 6; setting++) begin
         a = 20'($urandom_range(0, 20'hFFFFF));
         b = 20'($urandom_range(a, 20'hFFFFF));
         c = 20'($urandom_range(b, 20'hFFFFF));
         d = 20'($urandom_range(c, 20'hFFFFF));
         case (setting)
            0: set_windows(20'h00000, 20'h00000, 20'hFFFFF, 20'hFFFFF);
            1: set_windows(20'h00000, 20'hFFFFF, 20'h00000, 20'hFFFFF);
            2: set_windows(20'd60000, 20'd30000, 20'd95000, 20'd75000);
            3: set_windows(a, b, c, d);
            4: set_windows(20'd100, 20'd5000, 20'd2000, 20'd9000);
            default: set_windows(RESET_LOW_MIN, RESET_LOW_MAX, RESET_HIGH_MIN, RESET_HIGH_MAX);
         endcase
         repeat (4) send_clean_event();
         send_noise_event();
      end
   endtask

   task automatic test_random_events();
      repeat (18) begin
         if ($urandom_range(0, 3) == 0) gaps_on = !gaps_on;
         if ($urandom_range(0, 4) == 0) send_noise_event();
         else send_clean_event();
      end
      gaps_on = 1'b1;
   endtask

   task automatic test_full_backpressure();
      hold_on = 1'b1;
      gaps_on = 1'b0;
      repeat (6) send_clean_event();
      while (hold_on) @(posedge clock);
      gaps_on = 1'b1;
   endtask

   task automatic test_drain_pause();
      repeat (3) send_clean_event();
      wait_until_drained();
      repeat (3) send_clean_event();
      send_noise_event();
   endtask

   initial begin
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      win.low_min = RESET_LOW_MIN;
      win.low_max = RESET_LOW_MAX;
      win.high_min = RESET_HIGH_MIN;
      win.high_max = RESET_HIGH_MAX;
      err_accum = '0;
      evt_offset = '0;
      pat_offset = '0;
      for (int i = 0; i < NumSummary; i++) prim_word[i] = '0;
      for (int i = 0; i < 2 * NumIntegral; i++) cls[i] = CLASS_LOW;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_window_settings();
      test_random_events();
      test_full_backpressure();
      test_drain_pause();

      req_tvalid <= 1'b0;
      @(posedge clock);
      for (int n = 0; n < 20000 && pending_reports.size() != 0; n++) @(posedge clock);
      repeat (10) @(posedge clock);
      if (pending_reports.size() != 0) begin
         $display("%0t: %0d responses expected, got none", $time, pending_reports.size());
         errors++;
      end
      if (errors == 0) begin
         $display("helicity_consistency_checker_core_test: done, clean");
      end else begin
         $display("helicity_consistency_checker_core_test: done, errors");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("helicity_consistency_checker_core_test: done, errors");
      $finish;
   end

endmodule

>>> filelist.f
sv/helc_pkg.sv
sv/helc_classify.sv
sv/helicity_consistency_checker_core.sv
verif/helicity_consistency_checker_core_test.sv
